FILE: rtl/deq_pkg.sv
// shared types, codes and defaults for the double-ended queue
package deq_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 32;
    localparam int VALUE_W    = 32;
    localparam int COUNT_W    = 5;

    typedef enum logic [1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNUSED    = 2'd3
    } status_t;

    typedef struct packed {
        action_t              action;
        logic [VALUE_W-1:0]   push_value;
    } cmd_t;

    typedef struct packed {
        logic [VALUE_W-1:0]   popped_value;
        status_t              status;
        logic [VALUE_W-1:0]   front_value;
        logic [VALUE_W-1:0]   rear_value;
        logic [COUNT_W-1:0]   element_count;
    } result_t;

    typedef struct packed {
        logic push_front;
        logic push_rear;
        logic pop_front;
        logic pop_rear;
    } cell_ctrl_t;

endpackage

FILE: rtl/deq_cell.sv
// one slot of the queue chain, shifting toward either neighbor
module deq_cell #(
    parameter int DATA_W = deq_pkg::DATA_W_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  deq_pkg::cell_ctrl_t ctrl,
    input  logic [DATA_W-1:0]   push_value,
    input  logic [DATA_W-1:0]   left_data,
    input  logic                left_valid,
    input  logic [DATA_W-1:0]   right_data,
    input  logic                right_valid,
    output logic [DATA_W-1:0]   data,
    output logic                valid,
    output logic [DATA_W-1:0]   rear_data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctrl.push_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (ctrl.push_rear)
        begin
            // first empty slot takes the new element
            if (!valid_reg && left_valid)
            begin
                data_next  = push_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.pop_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (ctrl.pop_rear)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign valid     = valid_reg;
    assign rear_data = (valid_reg && !right_valid) ? data_reg : '0;

endmodule

FILE: rtl/double_ended_queue.sv
// top level: bounded double-ended queue built from a chain of shifting cells
//
//  channel | signals              | transfer
//  --------+----------------------+-------------------------------
//  command | start, busy, cmd     | start high while busy is low
//  result  | done, result         | the single cycle done is high
//
// for each command the cell chain updates at the accepting edge and the
// result register loads at the next one, from the rear element selection
// across the chain. done rises with the result register load, and busy is
// high from the accepting edge until that load. the receiver
// cannot stall. after reset the queue is empty and a command is taken at once.
module double_ended_queue #(
    parameter int DEPTH  = deq_pkg::DEPTH_DEF,
    parameter int DATA_W = deq_pkg::DATA_W_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  deq_pkg::cmd_t    cmd,
    output logic             done,
    output deq_pkg::result_t result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0]       cell_data [DEPTH];
    logic                    cell_valid [DEPTH];
    logic [DATA_W-1:0]       cell_rear [DEPTH];
    logic [DATA_W-1:0]       push_data;
    logic [DATA_W-1:0]       rear_sel;
    deq_pkg::cell_ctrl_t     ctrl;

    logic                    accept;
    logic                    is_push;
    logic                    full;
    logic                    empty;

    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic                    pend_reg;
    logic                    done_reg;
    logic [DATA_W-1:0]       rear_reg;
    logic [deq_pkg::VALUE_W-1:0] popped_reg;
    logic [deq_pkg::VALUE_W-1:0] popped_next;
    deq_pkg::status_t        status_reg;
    deq_pkg::status_t        status_next;
    deq_pkg::result_t        result_reg;

    assign busy      = pend_reg;
    assign accept    = start && !pend_reg;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign push_data = DATA_W'(cmd.push_value);

    always_comb
    begin
        is_push = cmd.action inside {deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR};
        ctrl    = '0;
        if (accept)
        begin
            case (cmd.action)
                deq_pkg::ACT_PUSH_FRONT: ctrl.push_front = !full;
                deq_pkg::ACT_PUSH_REAR:  ctrl.push_rear  = !full;
                deq_pkg::ACT_POP_FRONT:  ctrl.pop_front  = !empty;
                deq_pkg::ACT_POP_REAR:   ctrl.pop_rear   = !empty;
                default:                 ctrl            = '0;
            endcase
        end
    end

    always_comb
    begin
        status_next = deq_pkg::ST_OK;
        if (is_push && full)
        begin
            status_next = deq_pkg::ST_OVERFLOW;
        end
        else if (!is_push && empty)
        begin
            status_next = deq_pkg::ST_UNDERFLOW;
        end

        popped_next = '0;
        if (ctrl.pop_front)
        begin
            popped_next = deq_pkg::VALUE_W'(cell_data[0]);
        end
        else if (ctrl.pop_rear)
        begin
            popped_next = deq_pkg::VALUE_W'(rear_reg);
        end

        count_next = count_reg;
        if (ctrl.push_front || ctrl.push_rear)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctrl.pop_front || ctrl.pop_rear)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [DATA_W-1:0] l_data;
            logic              l_valid;
            logic [DATA_W-1:0] r_data;
            logic              r_valid;

            if (gi == 0)
            begin : g_head
                assign l_data  = push_data;
                assign l_valid = 1'b1;
            end
            else
            begin : g_mid
                assign l_data  = cell_data[gi-1];
                assign l_valid = cell_valid[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_data  = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_body
                assign r_data  = cell_data[gi+1];
                assign r_valid = cell_valid[gi+1];
            end

            deq_cell #(
                .DATA_W (DATA_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .push_value  (push_data),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi]),
                .rear_data   (cell_rear[gi])
            );
        end
    endgenerate

    // only the last occupied cell drives its value as rear value; every other cell drives zero
    always_comb
    begin
        rear_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rear_sel = rear_sel | cell_rear[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= accept;
            done_reg  <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            status_reg <= status_next;
        end
        if (pend_reg)
        begin
            rear_reg                 <= rear_sel;
            result_reg.popped_value  <= popped_reg;
            result_reg.status        <= status_reg;
            result_reg.front_value   <= cell_valid[0] ?
                                        deq_pkg::VALUE_W'(cell_data[0]) : '0;
            result_reg.rear_value    <= deq_pkg::VALUE_W'(rear_sel);
            result_reg.element_count <= deq_pkg::COUNT_W'(count_reg);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    logic [DEPTH-1:0] valid_vec;

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_vec[i] = cell_valid[i];
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count_reg))
        else $error("occupied cells disagree with element count");

    a_done_after_pend: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pend_reg) && !busy)
        else $error("result strobe without a pending command");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

endmodule

FILE: verif/deq_checker.sv
// checker for the double-ended queue: predicts each result and compares it on done
`timescale 1ns / 100ps

module deq_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  deq_pkg::cmd_t    cmd,
    input  logic             done,
    input  deq_pkg::result_t result,
    output int               fail_count,
    output int               n_pending
);

    localparam int DEPTH = deq_pkg::DEPTH_DEF;

    logic [deq_pkg::VALUE_W-1:0] slots [DEPTH];
    int                          head;
    int                          tail;
    int                          count;
    deq_pkg::result_t            awaited [$];
    deq_pkg::result_t            oldest;

    function automatic deq_pkg::result_t apply_action(input deq_pkg::cmd_t c);
        deq_pkg::result_t r;
        r        = '0;
        r.status = deq_pkg::ST_OK;
        case (c.action)
            deq_pkg::ACT_PUSH_FRONT, deq_pkg::ACT_PUSH_REAR:
            begin
                if (count >= DEPTH)
                begin
                    r.status = deq_pkg::ST_OVERFLOW;
                end
                else if (c.action == deq_pkg::ACT_PUSH_FRONT)
                begin
                    head        = (head + DEPTH - 1) % DEPTH;
                    slots[head] = c.push_value;
                    count++;
                end
                else
                begin
                    slots[tail] = c.push_value;
                    tail        = (tail + 1) % DEPTH;
                    count++;
                end
            end
            deq_pkg::ACT_POP_FRONT:
            begin
                if (count == 0)
                begin
                    r.status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    r.popped_value = slots[head];
                    head           = (head + 1) % DEPTH;
                    count--;
                end
            end
            deq_pkg::ACT_POP_REAR:
            begin
                if (count == 0)
                begin
                    r.status = deq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    tail           = (tail + DEPTH - 1) % DEPTH;
                    r.popped_value = slots[tail];
                    count--;
                end
            end
            default:
            begin
                r.status = deq_pkg::ST_OK;
            end
        endcase
        if (count != 0)
        begin
            r.front_value = slots[head];
            r.rear_value  = slots[(tail + DEPTH - 1) % DEPTH];
        end
        r.element_count = count[deq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name,
                               input logic [deq_pkg::VALUE_W-1:0] exp_v,
                               input logic [deq_pkg::VALUE_W-1:0] act_v);
        if (act_v !== exp_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head       = 0;
            tail       = 0;
            count      = 0;
            fail_count = 0;
            awaited.delete();
            n_pending <= 0;
        end
        else
        begin
            // results first: a result never belongs to a command taken at the same edge
            if (done === 1'b1)
            begin
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    oldest = awaited.pop_front();
                    check_field("popped_value", oldest.popped_value, result.popped_value);
                    check_field("status", deq_pkg::VALUE_W'(oldest.status),
                                deq_pkg::VALUE_W'(result.status));
                    check_field("front_value", oldest.front_value, result.front_value);
                    check_field("rear_value", oldest.rear_value, result.rear_value);
                    check_field("element_count", deq_pkg::VALUE_W'(oldest.element_count),
                                deq_pkg::VALUE_W'(result.element_count));
                end
            end
            if (start === 1'b1 && busy === 1'b0)
                awaited.push_back(apply_action(cmd));
            n_pending <= awaited.size();
        end
    end

endmodule

FILE: verif/tb_double_ended_queue.sv
// testbench top for the double-ended queue: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module tb_double_ended_queue;

    localparam int DEPTH       = deq_pkg::DEPTH_DEF;
    localparam int N_RANDOM    = 1100;
    localparam int CALM_ITEMS  = 150;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    deq_pkg::cmd_t    cmd;
    logic             done;
    deq_pkg::result_t result;
    int               fail_count;
    int               n_pending;

    double_ended_queue u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    deq_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .done       (done),
        .result     (result),
        .fail_count (fail_count),
        .n_pending  (n_pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // holds start until the transfer happens
    task automatic send(input deq_pkg::action_t a, input logic [deq_pkg::VALUE_W-1:0] v);
        deq_pkg::cmd_t c;
        c.action     = a;
        c.push_value = v;
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic pause(input int n);
        deq_pkg::cmd_t c;
        c.action     = ($urandom_range(1) == 1) ? deq_pkg::ACT_PUSH_REAR
                                                : deq_pkg::ACT_POP_FRONT;
        c.push_value = $urandom;
        start <= 1'b0;
        cmd   <= c;
        repeat (n) @(posedge clk);
    endtask

    // one edge first so the count includes the transfer just made
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (n_pending != 0)
            @(posedge clk);
    endtask

    function automatic deq_pkg::action_t pick_action(input int push_pct);
        if ($urandom_range(99) < push_pct)
            return ($urandom_range(1) == 1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_REAR;
        return ($urandom_range(1) == 1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_REAR;
    endfunction

    function automatic logic [deq_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int sent;
        int batch;
        int batch_len;
        int push_pct;
        int idle_pct;
        int b;
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: underflow on both ends, last element popped from each end
        send(deq_pkg::ACT_POP_FRONT, 32'h1234_5678);
        send(deq_pkg::ACT_POP_REAR, 32'hFFFF_FFFF);
        send(deq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF);
        send(deq_pkg::ACT_POP_REAR, 32'h0);
        send(deq_pkg::ACT_PUSH_REAR, 32'h0);
        send(deq_pkg::ACT_POP_FRONT, 32'hFFFF_FFFF);
        // fill to the limit, overflow from both ends, then pop one from the rear
        for (int i = 0; i < DEPTH; i++)
            send((i % 2 == 0) ? deq_pkg::ACT_PUSH_REAR : deq_pkg::ACT_PUSH_FRONT,
                 (i % 3 == 0) ? 32'hFFFF_FFFF : (i % 3 == 1) ? 32'h0 : $urandom);
        send(deq_pkg::ACT_PUSH_FRONT, 32'hA5A5_A5A5);
        send(deq_pkg::ACT_PUSH_REAR, 32'h5A5A_5A5A);
        send(deq_pkg::ACT_POP_REAR, 32'h0);
        drain();

        sent  = 0;
        batch = 0;
        while (sent < N_RANDOM)
        begin
            batch_len = $urandom_range(20, 80);
            case ($urandom_range(4))
                0:       push_pct = 85;
                1:       push_pct = 15;
                2:       push_pct = 65;
                3:       push_pct = 35;
                default: push_pct = 50;
            endcase
            case ($urandom_range(3))
                0:       idle_pct = 0;
                1:       idle_pct = 10;
                2:       idle_pct = 30;
                default: idle_pct = 60;
            endcase
            for (b = 0; b < batch_len && sent < N_RANDOM; b++)
            begin
                send(pick_action(push_pct), pick_value());
                sent++;
                if (sent < N_RANDOM - CALM_ITEMS && $urandom_range(99) < idle_pct)
                    pause($urandom_range(1, 6));
            end
            batch++;
            if (sent < N_RANDOM - CALM_ITEMS && (batch == 3 || $urandom_range(3) == 0))
                drain();
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && n_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/deq_pkg.sv
rtl/deq_cell.sv
rtl/double_ended_queue.sv
verif/deq_checker.sv
verif/tb_double_ended_queue.sv
